>>> design/config_line_tokenizer_unit_macros.svh
`ifndef CONFIG_LINE_TOKENIZER_UNIT_MACROS_SVH
`define CONFIG_LINE_TOKENIZER_UNIT_MACROS_SVH

// Implication checked on the same edge
`define CLTOK_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tokenizer check failed");

// Implication checked on the following edge
`define CLTOK_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tokenizer check failed");

`endif

>>> design/cltok_pkg.sv
`default_nettype none

package cltok_pkg;

   localparam int MAX_TOKEN_LENGTH_DEF = 255;
   localparam int TOKEN_LIMIT_DEF      = 16;
   localparam int QUEUE_DEPTH_DEF      = 2;

   localparam logic [4:0] MAX_TOKENS_RESET = 5'd16;
   localparam logic       CSR_MAX_TOKENS   = 1'b0;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ZERO    = 8'h00;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_DIGIT0  = 8'h30;
   localparam logic [7:0] CH_DIGIT9  = 8'h39;

   typedef enum logic [3:0] {
      BC_BLANK,
      BC_NEWLINE,
      BC_CR,
      BC_ZERO,
      BC_SEMI,
      BC_HASH,
      BC_QUOTE,
      BC_DOT,
      BC_DIGIT,
      BC_OTHER
   } byte_class_type;

   typedef enum logic [2:0] {
      EV_TOKEN,
      EV_TOKEN_END,
      EV_COMMENT,
      EV_SYNTAX,
      EV_TOO_MANY
   } event_kind_type;

   typedef enum logic [1:0] {
      TK_NUMBER,
      TK_FLOAT,
      TK_STRING,
      TK_QSTRING
   } token_kind_type;

   typedef struct packed {
      byte_class_type cls;
      logic           first;
      logic           last;
   } item_type;

   typedef struct packed {
      logic push;
      logic full;
   } front_ctl_type;

endpackage

`default_nettype wire

>>> design/cltok_front.sv
`default_nettype none

module cltok_front (
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_text_byte,
   input  wire logic                    req_first_byte,
   input  wire logic                    req_final_byte,
   input  wire logic                    queue_full,
   output cltok_pkg::front_ctl_type     ctl,
   output cltok_pkg::item_type          item
);

   cltok_pkg::byte_class_type cls;

   always_comb begin
      if (req_text_byte == cltok_pkg::CH_SPACE || req_text_byte == cltok_pkg::CH_TAB) begin
         cls = cltok_pkg::BC_BLANK;
      end else if (req_text_byte == cltok_pkg::CH_NEWLINE) begin
         cls = cltok_pkg::BC_NEWLINE;
      end else if (req_text_byte == cltok_pkg::CH_CR) begin
         cls = cltok_pkg::BC_CR;
      end else if (req_text_byte == cltok_pkg::CH_ZERO) begin
         cls = cltok_pkg::BC_ZERO;
      end else if (req_text_byte == cltok_pkg::CH_SEMI) begin
         cls = cltok_pkg::BC_SEMI;
      end else if (req_text_byte == cltok_pkg::CH_HASH) begin
         cls = cltok_pkg::BC_HASH;
      end else if (req_text_byte == cltok_pkg::CH_QUOTE) begin
         cls = cltok_pkg::BC_QUOTE;
      end else if (req_text_byte == cltok_pkg::CH_DOT) begin
         cls = cltok_pkg::BC_DOT;
      end else if (req_text_byte >= cltok_pkg::CH_DIGIT0 &&
                   req_text_byte <= cltok_pkg::CH_DIGIT9) begin
         cls = cltok_pkg::BC_DIGIT;
      end else begin
         cls = cltok_pkg::BC_OTHER;
      end
   end

   assign req_stall  = queue_full;
   assign ctl.full   = queue_full;
   assign ctl.push   = req_valid && !queue_full;
   assign item.cls   = cls;
   assign item.first = req_first_byte;
   assign item.last  = req_final_byte;

endmodule

`default_nettype wire

>>> design/cltok_queue.sv
`default_nettype none

module cltok_queue #(
   parameter int DEPTH = cltok_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cltok_pkg::item_type  push_item,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      pop_valid,
   output cltok_pkg::item_type       pop_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cltok_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> design/cltok_back.sv
`default_nettype none

module cltok_back #(
   parameter int MAX_TOKEN_LENGTH = cltok_pkg::MAX_TOKEN_LENGTH_DEF,
   parameter int TOKEN_LIMIT      = cltok_pkg::TOKEN_LIMIT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [4:0]           max_tokens,
   input  wire logic                 item_valid,
   input  wire cltok_pkg::item_type  item,
   output logic                      item_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_event_kind,
   output logic [1:0]                rsp_token_kind,
   output logic [7:0]                rsp_token_len,
   output logic [3:0]                rsp_token_position,
   output logic [4:0]                rsp_statement_tokens,
   output logic [15:0]               rsp_line_count
);

   localparam int TW = $clog2(TOKEN_LIMIT + 1);
   localparam int MW = (TW > 5) ? TW : 5;
   localparam int ZW = $clog2(MAX_TOKEN_LENGTH + 1);
   localparam int XW = (ZW > 8) ? ZW : 8;

   typedef enum logic [2:0] {
      PH_START,
      PH_BLANKS,
      PH_TOKSTART,
      PH_BARE,
      PH_QUOTED,
      PH_QCLOSED,
      PH_COMMENT,
      PH_HALT
   } phase_type;

   phase_type                 phase_ff, phase_in;
   cltok_pkg::token_kind_type kind_ff, kind_in;
   logic [ZW-1:0]             size_ff, size_in;
   logic [TW-1:0]             tokens_ff, tokens_in;
   logic [15:0]               line_ff, line_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                ev_kind_ff, ev_kind_in;
   logic [1:0]                tok_kind_ff, tok_kind_in;
   logic [7:0]                tok_size_ff, tok_size_in;
   logic [3:0]                tok_pos_ff, tok_pos_in;
   logic [4:0]                stmt_ff, stmt_in;
   logic [15:0]               ev_line_ff, ev_line_in;

   logic                      ev_fire;
   logic [MW-1:0]             limit;
   logic [MW-1:0]             cfg_wide;

   assign item_pop = item_valid && (!rsp_valid_ff || !rsp_stall);

   assign cfg_wide = MW'(max_tokens);
   always_comb begin
      if (cfg_wide == '0) begin
         limit = MW'(1);
      end else if (cfg_wide > MW'(TOKEN_LIMIT)) begin
         limit = MW'(TOKEN_LIMIT);
      end else begin
         limit = cfg_wide;
      end
   end

   always_comb begin
      logic          start_req;
      logic          end_req;
      logic          bare_req;
      logic          failed;
      logic [MW:0]   tk_next;
      logic [MW-1:0] tk_wide;
      logic [XW-1:0] sz_wide;

      phase_in    = phase_ff;
      kind_in     = kind_ff;
      size_in     = size_ff;
      tokens_in   = tokens_ff;
      line_in     = line_ff;
      ev_fire     = 1'b0;
      ev_kind_in  = cltok_pkg::EV_TOKEN;
      tok_kind_in = '0;
      tok_size_in = '0;
      tok_pos_in  = '0;
      stmt_in     = '0;
      start_req   = 1'b0;
      end_req     = 1'b0;
      bare_req    = 1'b0;
      failed      = 1'b0;
      tk_next     = '0;
      tk_wide     = '0;
      sz_wide     = '0;

      if (item.first) begin
         phase_in  = PH_START;
         kind_in   = cltok_pkg::TK_NUMBER;
         size_in   = '0;
         tokens_in = '0;
         line_in   = 16'd1;
      end
      ev_line_in = line_in;

      if (phase_in != PH_HALT) begin
         case (phase_in)
            PH_START, PH_BLANKS: begin
               if (item.cls == cltok_pkg::BC_BLANK) begin
                  phase_in = PH_BLANKS;
               end else if (item.cls == cltok_pkg::BC_NEWLINE) begin
                  phase_in = PH_START;
                  if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
               end else if (item.cls == cltok_pkg::BC_CR) begin
                  phase_in = PH_COMMENT;
               end else begin
                  tokens_in = '0;
                  start_req = 1'b1;
               end
            end
            PH_TOKSTART: begin
               start_req = 1'b1;
            end
            PH_BARE: begin
               if (item.cls == cltok_pkg::BC_BLANK || item.cls == cltok_pkg::BC_SEMI) begin
                  end_req = 1'b1;
               end else if (item.cls == cltok_pkg::BC_NEWLINE ||
                            item.cls == cltok_pkg::BC_CR ||
                            item.cls == cltok_pkg::BC_ZERO) begin
                  failed = 1'b1;
               end else begin
                  bare_req = 1'b1;
               end
            end
            PH_QUOTED: begin
               if (item.cls == cltok_pkg::BC_QUOTE) begin
                  phase_in = PH_QCLOSED;
               end else if (item.cls == cltok_pkg::BC_NEWLINE ||
                            item.cls == cltok_pkg::BC_CR ||
                            item.cls == cltok_pkg::BC_ZERO) begin
                  failed = 1'b1;
               end else if (size_in < ZW'(MAX_TOKEN_LENGTH)) begin
                  size_in = size_in + 1'b1;
               end
            end
            PH_QCLOSED: begin
               if (item.cls == cltok_pkg::BC_QUOTE) begin
                  phase_in = PH_QCLOSED;
               end else if (item.cls == cltok_pkg::BC_BLANK ||
                            item.cls == cltok_pkg::BC_SEMI) begin
                  end_req = 1'b1;
               end else begin
                  failed = 1'b1;
               end
            end
            PH_COMMENT: begin
               if (item.cls == cltok_pkg::BC_NEWLINE) begin
                  phase_in = PH_START;
                  if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
               end
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase

         if (start_req) begin
            case (item.cls)
               cltok_pkg::BC_BLANK, cltok_pkg::BC_SEMI, cltok_pkg::BC_ZERO,
               cltok_pkg::BC_NEWLINE, cltok_pkg::BC_CR: begin
                  failed = 1'b1;
               end
               cltok_pkg::BC_HASH: begin
                  ev_fire    = 1'b1;
                  ev_kind_in = cltok_pkg::EV_COMMENT;
                  tk_wide    = MW'(tokens_in);
                  stmt_in    = tk_wide[4:0];
                  tokens_in  = '0;
                  phase_in   = PH_COMMENT;
               end
               cltok_pkg::BC_QUOTE: begin
                  kind_in  = cltok_pkg::TK_QSTRING;
                  size_in  = '0;
                  phase_in = PH_QUOTED;
               end
               default: begin
                  kind_in  = cltok_pkg::TK_NUMBER;
                  size_in  = '0;
                  phase_in = PH_BARE;
                  bare_req = 1'b1;
               end
            endcase
         end

         if (bare_req) begin
            if (item.cls == cltok_pkg::BC_DOT && kind_in == cltok_pkg::TK_NUMBER) begin
               kind_in = cltok_pkg::TK_FLOAT;
            end else if (item.cls != cltok_pkg::BC_DIGIT) begin
               if (kind_in == cltok_pkg::TK_NUMBER) begin
                  kind_in = cltok_pkg::TK_STRING;
               end else if (kind_in == cltok_pkg::TK_FLOAT) begin
                  failed = 1'b1;
               end
            end
            if (!failed && size_in < ZW'(MAX_TOKEN_LENGTH)) begin
               size_in = size_in + 1'b1;
            end
         end

         if (end_req) begin
            tk_wide = MW'(tokens_in);
            tk_next = {1'b0, tk_wide} + 1'b1;
            sz_wide = XW'(size_in);
            if (item.cls == cltok_pkg::BC_SEMI) begin
               ev_fire     = 1'b1;
               ev_kind_in  = cltok_pkg::EV_TOKEN_END;
               tok_kind_in = kind_in;
               tok_size_in = (sz_wide > XW'(255)) ? 8'hFF : sz_wide[7:0];
               tok_pos_in  = tk_wide[3:0];
               stmt_in     = tk_next[4:0];
               tokens_in   = '0;
               phase_in    = PH_START;
            end else if (tk_next >= {1'b0, limit}) begin
               ev_fire    = 1'b1;
               ev_kind_in = cltok_pkg::EV_TOO_MANY;
               phase_in   = PH_HALT;
            end else begin
               ev_fire     = 1'b1;
               ev_kind_in  = cltok_pkg::EV_TOKEN;
               tok_kind_in = kind_in;
               tok_size_in = (sz_wide > XW'(255)) ? 8'hFF : sz_wide[7:0];
               tok_pos_in  = tk_wide[3:0];
               tokens_in   = tokens_in + 1'b1;
               phase_in    = PH_TOKSTART;
            end
         end

         if (item.last && !failed && phase_in != PH_HALT &&
             (phase_in == PH_BLANKS || phase_in == PH_TOKSTART || phase_in == PH_BARE ||
              phase_in == PH_QUOTED || phase_in == PH_QCLOSED)) begin
            failed = 1'b1;
         end

         if (failed) begin
            ev_fire     = 1'b1;
            ev_kind_in  = cltok_pkg::EV_SYNTAX;
            tok_kind_in = '0;
            tok_size_in = '0;
            tok_pos_in  = '0;
            stmt_in     = '0;
            phase_in    = PH_HALT;
         end

         if (item.last) begin
            phase_in = PH_HALT;
         end
      end

      rsp_valid_in = item_pop ? ev_fire : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         kind_ff      <= cltok_pkg::TK_NUMBER;
         size_ff      <= '0;
         tokens_ff    <= '0;
         line_ff      <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            phase_ff  <= phase_in;
            kind_ff   <= kind_in;
            size_ff   <= size_in;
            tokens_ff <= tokens_in;
            line_ff   <= line_in;
         end
      end
      if (item_pop && ev_fire) begin
         ev_kind_ff  <= ev_kind_in;
         tok_kind_ff <= tok_kind_in;
         tok_size_ff <= tok_size_in;
         tok_pos_ff  <= tok_pos_in;
         stmt_ff     <= stmt_in;
         ev_line_ff  <= ev_line_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_kind       = ev_kind_ff;
   assign rsp_token_kind       = tok_kind_ff;
   assign rsp_token_len        = tok_size_ff;
   assign rsp_token_position   = tok_pos_ff;
   assign rsp_statement_tokens = stmt_ff;
   assign rsp_line_count       = ev_line_ff;

endmodule

`default_nettype wire

>>> design/config_line_tokenizer_unit.sv
// Configuration text tokenizer, one byte per item.
// Input channel (req_*): one text byte per item with first_byte, which restarts
// parsing at line 1, and final_byte, which marks the end of the text.
// Result channel (rsp_*): at most one item per byte: a token with kind, length,
// position and line, a statement end, a comment, a syntax error or a too-many-tokens event.
// An accepted byte is queued, parsed, and its result registered before it is offered on rsp_.
// Throughput: one byte per cycle while rsp_ is not stalled; the front classifier and
// the back parser are joined by a two-entry queue, and the parser's single state
// update per byte sets the rate.
// A stall on rsp_ holds the result register; the parser stops and the queue fills,
// after which req_stall rises. Bytes after a reported error or the final byte are
// swallowed without result until a byte with first_byte set.
// Reset (synchronous) empties the queue, drops any pending result, returns the
// parser to statement start at line 1 and sets max_tokens to 16.
// CSR: max_tokens at byte address 0, written and read over the APB-style port; the user
// must access it only while the block is idle, which the block itself does not enforce.
`default_nettype none

module config_line_tokenizer_unit #(
   parameter int MAX_TOKEN_LENGTH = cltok_pkg::MAX_TOKEN_LENGTH_DEF,
   parameter int TOKEN_LIMIT      = cltok_pkg::TOKEN_LIMIT_DEF,
   parameter int QUEUE_DEPTH      = cltok_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_event_kind,
   output logic [1:0]       rsp_token_kind,
   output logic [7:0]       rsp_token_len,
   output logic [3:0]       rsp_token_position,
   output logic [4:0]       rsp_statement_tokens,
   output logic [15:0]      rsp_line_count,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [4:0]               max_tokens_ff, max_tokens_in;
   cltok_pkg::front_ctl_type front_ctl;
   cltok_pkg::item_type      front_item;
   cltok_pkg::item_type      back_item;
   logic                     queue_full;
   logic                     back_valid;
   logic                     back_pop;

   assign csr_pready = 1'b1;

   always_comb begin
      max_tokens_in = max_tokens_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == cltok_pkg::CSR_MAX_TOKENS) begin
         max_tokens_in = csr_pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tokens_ff <= cltok_pkg::MAX_TOKENS_RESET;
      end else begin
         max_tokens_ff <= max_tokens_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == cltok_pkg::CSR_MAX_TOKENS) ?
                       {27'd0, max_tokens_ff} : 32'd0;

   cltok_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_first_byte (req_first_byte),
      .req_final_byte (req_final_byte),
      .queue_full     (queue_full),
      .ctl            (front_ctl),
      .item           (front_item)
   );

   cltok_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_ctl.push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_valid (back_valid),
      .pop_item  (back_item)
   );

   cltok_back #(
      .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
      .TOKEN_LIMIT      (TOKEN_LIMIT)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .max_tokens           (max_tokens_ff),
      .item_valid           (back_valid),
      .item                 (back_item),
      .item_pop             (back_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_token_kind       (rsp_token_kind),
      .rsp_token_len        (rsp_token_len),
      .rsp_token_position   (rsp_token_position),
      .rsp_statement_tokens (rsp_statement_tokens),
      .rsp_line_count       (rsp_line_count)
   );

endmodule

`default_nettype wire

>>> design/cltok_checker.sv
`default_nettype none
`include "config_line_tokenizer_unit_macros.svh"

module cltok_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_event_kind,
   input wire logic [1:0]  rsp_token_kind,
   input wire logic [7:0]  rsp_token_len,
   input wire logic [3:0]  rsp_token_position,
   input wire logic [4:0]  rsp_statement_tokens,
   input wire logic [15:0] rsp_line_count
);

   logic non_token_event;
   logic token_fields_zero;

   assign non_token_event = rsp_valid && (rsp_event_kind == cltok_pkg::EV_COMMENT ||
                                          rsp_event_kind == cltok_pkg::EV_SYNTAX ||
                                          rsp_event_kind == cltok_pkg::EV_TOO_MANY);
   assign token_fields_zero = rsp_token_kind == 2'd0 && rsp_token_len == 8'd0 &&
                              rsp_token_position == 4'd0;

   `CLTOK_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_kind))

   `CLTOK_ASSERT_NOW(a_no_token_fields, non_token_event, token_fields_zero)

   `CLTOK_ASSERT_NOW(a_mid_token_no_count, rsp_valid && rsp_event_kind == cltok_pkg::EV_TOKEN, rsp_statement_tokens == 5'd0)

   `CLTOK_ASSERT_NOW(a_line_nonzero, rsp_valid, rsp_line_count != 16'd0)

   `CLTOK_ASSERT_NOW(a_ready_after_reset, $past(reset), !req_stall && !rsp_valid)

endmodule

bind config_line_tokenizer_unit cltok_checker u_cltok_checker (.*);

`default_nettype wire
